>>> hw/rtl/array_permute_engine_macros.svh
// assertion macros shared by the array permute engine checkers
// no dependencies; include by bare file name
`ifndef ARRAY_PERMUTE_ENGINE_MACROS_SVH
`define ARRAY_PERMUTE_ENGINE_MACROS_SVH

// same-cycle implication
`define APE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define APE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ape_pkg.sv
// shared types and codes for the array permute engine
// no dependencies
`timescale 1ns / 1ps

package ape_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WORD_W   = 32;
   localparam int OP_W     = 3;

   typedef logic [OP_W-1:0]          op_code_type;
   typedef logic [1:0]               status_type;
   typedef logic signed [WORD_W-1:0] word_type;

   localparam op_code_type OP_APPEND  = 3'd0;
   localparam op_code_type OP_REVERSE = 3'd1;
   localparam op_code_type OP_SWAP    = 3'd2;
   localparam op_code_type OP_ROTATE  = 3'd3;
   localparam op_code_type OP_HALVES  = 3'd4;
   localparam op_code_type OP_READ    = 3'd5;

   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_FULL = 2'd1;
   localparam status_type ST_ARG  = 2'd2;

endpackage

>>> hw/rtl/array_permute_engine.sv
// Array permute engine: one item in, one result item out, one item at a time. The 16 words
// live in a single-write, dual-read synchronous memory, so every word move is a read followed
// by a write. Reverse, swap pairs and reverse halves swap two entries at a time (check, read
// both, write low, write high). Rotate right moves one word at a time (read below, write up).
// A finished result waits in an output register, and the next item is taken while it waits.
// Depends on ape_pkg.
`timescale 1ns / 1ps

module array_permute_engine
   import ape_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_type,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic [CNT_W-1:0]        req_split_point,
   input  logic [IDX_W-1:0]        req_read_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WORD_W-1:0] rsp_read_word,
   output logic [CNT_W-1:0]        rsp_fill_level,
   output logic [1:0]              rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_WAIT,
      S_SW_CHK,
      S_SW_RD,
      S_SW_WLO,
      S_SW_WHI,
      S_ROT_CAP,
      S_ROT_RD,
      S_ROT_WR,
      S_ROT_FIN,
      S_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   op_code_type op_ff, op_in;
   logic [CNT_W-1:0] split_ff, split_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic        phase2_ff, phase2_in;
   word_type    last_ff, last_in;
   word_type    word_ff, word_in;
   status_type  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_word_ff, rsp_word_in;
   logic [CNT_W-1:0] rsp_fill_ff, rsp_fill_in;
   status_type  rsp_status_ff, rsp_status_in;

   // word memory
   word_type         mem [CAPACITY];
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   word_type         mem_wd;
   logic             rd_en;
   logic [IDX_W-1:0] ra_a;
   logic [IDX_W-1:0] ra_b;
   word_type         rd_a_ff;
   word_type         rd_b_ff;

   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_a_ff <= mem[ra_a];
         rd_b_ff <= mem[ra_b];
      end
   end

   // reads and writes never fall in the same cycle, so no entry is read while written
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      op_in         = op_ff;
      split_in      = split_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cnt_in        = cnt_ff;
      phase2_in     = phase2_ff;
      last_in       = last_ff;
      word_in       = word_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_wa        = lo_ff;
      mem_wd        = rd_b_ff;
      rd_en         = 1'b0;
      ra_a          = lo_ff;
      ra_b          = hi_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_type;
               split_in  = req_split_point;
               status_in = ST_OK;
               word_in   = '0;
               phase2_in = 1'b0;
               state_in  = S_DONE;
               case (req_type)
                  OP_APPEND: begin
                     if (fill_ff >= CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        mem_wa  = fill_ff[IDX_W-1:0];
                        mem_wd  = req_value;
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  OP_REVERSE: begin
                     lo_in    = '0;
                     hi_in    = IDX_W'(fill_ff - CNT_W'(1));
                     cnt_in   = fill_ff >> 1;
                     state_in = S_SW_CHK;
                  end
                  OP_SWAP: begin
                     lo_in    = '0;
                     hi_in    = IDX_W'(1);
                     cnt_in   = fill_ff >> 1;
                     state_in = S_SW_CHK;
                  end
                  OP_ROTATE: begin
                     if (fill_ff != '0) begin
                        rd_en    = 1'b1;
                        ra_a     = IDX_W'(fill_ff - CNT_W'(1));
                        hi_in    = IDX_W'(fill_ff - CNT_W'(1));
                        state_in = S_ROT_CAP;
                     end
                  end
                  OP_HALVES: begin
                     if (req_split_point > fill_ff) begin
                        status_in = ST_ARG;
                     end else begin
                        lo_in     = '0;
                        hi_in     = IDX_W'(req_split_point - CNT_W'(1));
                        cnt_in    = req_split_point >> 1;
                        phase2_in = 1'b1;
                        state_in  = S_SW_CHK;
                     end
                  end
                  OP_READ: begin
                     if (CNT_W'(req_read_index) < fill_ff) begin
                        rd_en    = 1'b1;
                        ra_a     = req_read_index;
                        state_in = S_RD_WAIT;
                     end else begin
                        status_in = ST_ARG;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            word_in  = rd_a_ff;
            state_in = S_DONE;
         end
         S_SW_CHK: begin
            if (cnt_ff == '0) begin
               if (phase2_ff) begin
                  // second span of reverse halves
                  phase2_in = 1'b0;
                  lo_in     = split_ff[IDX_W-1:0];
                  hi_in     = IDX_W'(fill_ff - CNT_W'(1));
                  cnt_in    = (fill_ff - split_ff) >> 1;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_SW_RD;
            end
         end
         S_SW_RD: begin
            rd_en    = 1'b1;
            ra_a     = lo_ff;
            ra_b     = hi_ff;
            state_in = S_SW_WLO;
         end
         S_SW_WLO: begin
            mem_we   = 1'b1;
            mem_wa   = lo_ff;
            mem_wd   = rd_b_ff;
            state_in = S_SW_WHI;
         end
         S_SW_WHI: begin
            mem_we = 1'b1;
            mem_wa = hi_ff;
            mem_wd = rd_a_ff;
            cnt_in = cnt_ff - CNT_W'(1);
            if (op_ff == OP_SWAP) begin
               lo_in = lo_ff + IDX_W'(2);
               hi_in = hi_ff + IDX_W'(2);
            end else begin
               lo_in = lo_ff + IDX_W'(1);
               hi_in = hi_ff - IDX_W'(1);
            end
            state_in = S_SW_CHK;
         end
         S_ROT_CAP: begin
            last_in = rd_a_ff;
            if (hi_ff == '0) begin
               state_in = S_ROT_FIN;
            end else begin
               state_in = S_ROT_RD;
            end
         end
         S_ROT_RD: begin
            rd_en    = 1'b1;
            ra_a     = hi_ff - IDX_W'(1);
            state_in = S_ROT_WR;
         end
         S_ROT_WR: begin
            mem_we = 1'b1;
            mem_wa = hi_ff;
            mem_wd = rd_a_ff;
            hi_in  = hi_ff - IDX_W'(1);
            if (hi_ff == IDX_W'(1)) begin
               state_in = S_ROT_FIN;
            end else begin
               state_in = S_ROT_RD;
            end
         end
         S_ROT_FIN: begin
            mem_we   = 1'b1;
            mem_wa   = '0;
            mem_wd   = last_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = word_ff;
               rsp_fill_in   = fill_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         phase2_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_word_ff   <= '0;
         rsp_fill_ff   <= '0;
         rsp_status_ff <= ST_OK;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         phase2_ff     <= phase2_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      split_ff      <= split_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cnt_ff        <= cnt_in;
      last_ff       <= last_in;
      word_ff       <= word_in;
      status_ff     <= status_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_word  = rsp_word_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> hw/rtl/ape_checker.sv
// port-level checks for the array permute engine, bound to the top level
// depends on ape_pkg and array_permute_engine_macros.svh
`timescale 1ns / 1ps
`include "array_permute_engine_macros.svh"

module ape_checker
   import ape_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [WORD_W-1:0] rsp_read_word,
   input logic [CNT_W-1:0]         rsp_fill_level,
   input logic [1:0]               rsp_status
);

   `APE_ASSERT_IMP(a_fill_range, clock, reset, rsp_valid, rsp_fill_level <= CNT_W'(CAPACITY), "fill level beyond capacity")
   `APE_ASSERT_IMP(a_full_level, clock, reset, rsp_valid && rsp_status == ST_FULL, rsp_fill_level == CNT_W'(CAPACITY), "full status with room left")
   `APE_ASSERT_IMP(a_err_word, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_read_word == '0, "nonzero word on failed item")
   `APE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_word) && $stable(rsp_fill_level) && $stable(rsp_status), "stalled item changed")

endmodule

bind array_permute_engine ape_checker u_ape_checker (.*);
